>>> hdl/qrs_pkg.sv
// shared types and widths for the quadratic root solver
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int COEFF_W  = 16;                  // coefficient width, signed q8.8
    localparam int FRAC     = 16;                  // fraction bits of the roots
    localparam int ROOT_OUT_W = 32;                // width of one root field
    localparam int DISC_W   = 2 * COEFF_W + 2;     // signed discriminant
    localparam int ABSD_W   = DISC_W - 1;          // magnitude of the discriminant
    localparam int SQ_STEPS = (ABSD_W + 2 * FRAC + 1) / 2;
    localparam int RADX_W   = 2 * SQ_STEPS;        // scaled radicand
    localparam int ROOT_W   = SQ_STEPS;            // integer square root
    localparam int REM_W    = ROOT_W + 3;          // square root remainder
    localparam int P_W      = COEFF_W + FRAC + 1;  // -b scaled to the root format
    localparam int DEN_W    = COEFF_W + 1;         // 2|a|
    localparam int F_W      = ROOT_W + 3;          // floored numerator, signed
    localparam int M_W      = F_W;                 // numerator magnitude
    localparam int V_W      = M_W + 2;             // signed quotient before clamping

    typedef enum logic [1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_EQUAL    = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_DEGEN    = 2'd3
    } kind_t;

    // travels beside the square root cells
    typedef struct packed {
        logic signed [P_W-1:0] p;
        logic                  a_neg;
        logic [DEN_W-1:0]      den;
        kind_t                 kind;
    } side_t;

    // travels beside the divider cells
    typedef struct packed {
        kind_t kind;
        logic  neg1;
        logic  neg2;
    } dside_t;

endpackage

>>> hdl/qrs_front.sv
// coefficient capture, products and discriminant classification
`timescale 1ns / 1ps

module qrs_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [qrs_pkg::COEFF_W-1:0]   a,
    input  logic signed [qrs_pkg::COEFF_W-1:0]   b,
    input  logic signed [qrs_pkg::COEFF_W-1:0]   c,
    output logic                                 out_valid,
    output logic [qrs_pkg::RADX_W-1:0]           radicand,
    output qrs_pkg::side_t                       side
);
    import qrs_pkg::*;

    logic [2:0]                   vld_reg;
    logic signed [COEFF_W-1:0]    a1_reg, b1_reg, c1_reg;
    logic signed [COEFF_W-1:0]    a2_reg, b2_reg;
    logic signed [2*COEFF_W-1:0]  bb_reg, ac_reg;
    logic [RADX_W-1:0]            rad_reg;
    side_t                        side_reg;

    logic signed [DISC_W-1:0]     disc;
    logic [ABSD_W-1:0]            absd;
    logic signed [DISC_W-1:0]     disc_neg;
    side_t                        side_next;
    logic signed [P_W-1:0]        b_ext;
    logic signed [DEN_W-1:0]      a_ext;

    always_comb begin
        disc     = DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
        disc_neg = -disc;
        absd     = disc[DISC_W-1] ? disc_neg[ABSD_W-1:0] : disc[ABSD_W-1:0];
        b_ext    = P_W'(b2_reg);
        a_ext    = DEN_W'(a2_reg);
        side_next.p     = -(b_ext <<< FRAC);
        side_next.a_neg = a2_reg[COEFF_W-1];
        side_next.den   = a2_reg[COEFF_W-1] ? DEN_W'(-(a_ext <<< 1)) : DEN_W'(a_ext <<< 1);
        if (a2_reg == '0) begin
            side_next.kind = KIND_DEGEN;
        end else if (disc[DISC_W-1]) begin
            side_next.kind = KIND_COMPLEX;
        end else if (disc == '0) begin
            side_next.kind = KIND_EQUAL;
        end else begin
            side_next.kind = KIND_DISTINCT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= a;
            b1_reg   <= b;
            c1_reg   <= c;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            bb_reg   <= b1_reg * b1_reg;
            ac_reg   <= a1_reg * c1_reg;
            rad_reg  <= RADX_W'(absd) << (2 * FRAC);
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign radicand  = rad_reg;
    assign side      = side_reg;

endmodule

>>> hdl/qrs_sqrt_cell.sv
// one digit of the integer square root, two radicand bits per cell
`timescale 1ns / 1ps

module qrs_sqrt_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [qrs_pkg::RADX_W-1:0]  in_x,
    input  logic [qrs_pkg::REM_W-1:0]   in_rem,
    input  logic [qrs_pkg::ROOT_W-1:0]  in_root,
    input  qrs_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [qrs_pkg::RADX_W-1:0]  out_x,
    output logic [qrs_pkg::REM_W-1:0]   out_rem,
    output logic [qrs_pkg::ROOT_W-1:0]  out_root,
    output qrs_pkg::side_t              out_side
);
    import qrs_pkg::*;

    logic                valid_reg;
    logic [RADX_W-1:0]   x_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    side_t               side_reg;

    logic [REM_W-1:0]    rem_sh, trial, rem_next;
    logic                ge;

    always_comb begin
        rem_sh   = {in_rem[REM_W-3:0], in_x[RADX_W-1 -: 2]};
        trial    = REM_W'({in_root, 2'b01});
        ge       = (rem_sh >= trial);
        rem_next = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= in_x << 2;
            rem_reg  <= rem_next;
            root_reg <= {in_root[ROOT_W-2:0], ge};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

>>> hdl/qrs_div_cell.sv
// one quotient bit of both root divisions
`timescale 1ns / 1ps

module qrs_div_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [qrs_pkg::M_W-1:0]    in_n1,
    input  logic [qrs_pkg::DEN_W-1:0]  in_r1,
    input  logic [qrs_pkg::M_W-1:0]    in_n2,
    input  logic [qrs_pkg::DEN_W-1:0]  in_r2,
    input  logic [qrs_pkg::DEN_W-1:0]  in_den,
    input  qrs_pkg::dside_t            in_side,
    output logic                       out_valid,
    output logic [qrs_pkg::M_W-1:0]    out_n1,
    output logic [qrs_pkg::DEN_W-1:0]  out_r1,
    output logic [qrs_pkg::M_W-1:0]    out_n2,
    output logic [qrs_pkg::DEN_W-1:0]  out_r2,
    output logic [qrs_pkg::DEN_W-1:0]  out_den,
    output qrs_pkg::dside_t            out_side
);
    import qrs_pkg::*;

    logic              valid_reg;
    logic [M_W-1:0]    n1_reg, n2_reg;
    logic [DEN_W-1:0]  r1_reg, r2_reg, den_reg;
    dside_t            side_reg;

    logic [DEN_W:0]    sh1, sh2, d1, d2;
    logic              ge1, ge2;

    // numerator bits shift out on top, quotient bits shift in at the bottom
    always_comb begin
        sh1 = {in_r1, in_n1[M_W-1]};
        sh2 = {in_r2, in_n2[M_W-1]};
        ge1 = (sh1 >= {1'b0, in_den});
        ge2 = (sh2 >= {1'b0, in_den});
        d1  = ge1 ? (sh1 - {1'b0, in_den}) : sh1;
        d2  = ge2 ? (sh2 - {1'b0, in_den}) : sh2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg   <= {in_n1[M_W-2:0], ge1};
            n2_reg   <= {in_n2[M_W-2:0], ge2};
            r1_reg   <= d1[DEN_W-1:0];
            r2_reg   <= d2[DEN_W-1:0];
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_n1    = n1_reg;
    assign out_r1    = r1_reg;
    assign out_n2    = n2_reg;
    assign out_r2    = r2_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

>>> hdl/quadratic_root_solver.sv
// quadratic root solver top level: discriminant, square root row, divider row
//
//  channel | dir | tdata                              | tuser
//  s_      | in  | coeff_a, coeff_b, coeff_c (16 ea)  | -
//  m_      | out | root1_re, root1_im, root2_re,      | root_kind, saturated
//          |     | root2_im (32 ea)                   |
//
// one beat per cycle in and out while m_ is not stalled; the pipeline is the products and
// discriminant stages, 33 square root cells, 1 numerator stage, 36 divider cells
// and the output register
// aresetn clears only the valid bits; no clearing pass is needed
// a stall on m_ freezes the whole row of cells and drops s_tready; bubbles
// in flight are kept
`timescale 1ns / 1ps

module quadratic_root_solver (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // coeff_a[15:0], coeff_b[31:16], coeff_c[47:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // root1_real, root1_imag, root2_real, root2_imag
    output logic [2:0]   m_tuser    // root_kind[1:0], saturated[2]
);
    import qrs_pkg::*;

    logic en;

    // front end
    logic               f_valid;
    logic [RADX_W-1:0]  f_rad;
    side_t              f_side;

    // square root row
    logic               sq_valid [0:SQ_STEPS];
    logic [RADX_W-1:0]  sq_x     [0:SQ_STEPS];
    logic [REM_W-1:0]   sq_rem   [0:SQ_STEPS];
    logic [ROOT_W-1:0]  sq_root  [0:SQ_STEPS];
    side_t              sq_side  [0:SQ_STEPS];

    // divider row
    logic               dv_valid [0:M_W];
    logic [M_W-1:0]     dv_n1    [0:M_W];
    logic [DEN_W-1:0]   dv_r1    [0:M_W];
    logic [M_W-1:0]     dv_n2    [0:M_W];
    logic [DEN_W-1:0]   dv_r2    [0:M_W];
    logic [DEN_W-1:0]   dv_den   [0:M_W];
    dside_t             dv_side  [0:M_W];

    // numerator stage
    logic               pv_reg;
    logic [M_W-1:0]     m1_reg, m2_reg;
    logic [DEN_W-1:0]   den_reg;
    dside_t             pside_reg;
    logic [M_W:0]       lane1, lane2;

    // output stage
    logic               ov_reg;
    logic [127:0]       odata_reg, odata_next;
    logic [2:0]         ouser_reg, ouser_next;

    assign en       = !ov_reg || m_tready;
    assign s_tready = en;

    qrs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .a         (s_tdata[15:0]),
        .b         (s_tdata[31:16]),
        .c         (s_tdata[47:32]),
        .out_valid (f_valid),
        .radicand  (f_rad),
        .side      (f_side)
    );

    assign sq_valid[0] = f_valid;
    assign sq_x[0]     = f_rad;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = f_side;

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_x      (sq_x[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_valid[i+1]),
            .out_x     (sq_x[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // floor(|p + q*sqrt|) with sign; s is the floored root, ex marks it exact
    function automatic logic [M_W:0] lane_mag(input logic signed [F_W-1:0] p,
                                              input logic qp, input logic qn,
                                              input logic [ROOT_W-1:0] s,
                                              input logic ex);
        logic signed [F_W-1:0] s_ext;
        logic signed [F_W-1:0] f;
        logic signed [F_W-1:0] mag;
        logic                  neg;
        s_ext = F_W'(s);
        f     = p;
        if (qp) f = f + s_ext;
        if (qn) f = f - s_ext - F_W'(!ex);
        neg   = f[F_W-1];
        mag   = neg ? (-f - F_W'((qp || qn) && !ex)) : f;
        return {neg, M_W'(mag)};
    endfunction

    always_comb begin
        logic signed [F_W-1:0] pa;
        logic                  ex, an, is_dist, cplx;
        side_t                 sd;
        sd      = sq_side[SQ_STEPS];
        ex      = (sq_rem[SQ_STEPS] == '0);
        an      = sd.a_neg;
        is_dist = (sd.kind == KIND_DISTINCT);
        cplx    = (sd.kind == KIND_COMPLEX);
        pa      = an ? -F_W'(sd.p) : F_W'(sd.p);
        lane1 = lane_mag(pa, is_dist && !an, is_dist && an, sq_root[SQ_STEPS], ex);
        if (cplx) begin
            lane2 = lane_mag('0, !an, an, sq_root[SQ_STEPS], ex);
        end else begin
            lane2 = lane_mag(pa, is_dist && an, is_dist && !an, sq_root[SQ_STEPS], ex);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= sq_valid[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg         <= lane1[M_W-1:0];
            m2_reg         <= lane2[M_W-1:0];
            den_reg        <= sq_side[SQ_STEPS].den;
            pside_reg.kind <= sq_side[SQ_STEPS].kind;
            pside_reg.neg1 <= lane1[M_W];
            pside_reg.neg2 <= lane2[M_W];
        end
    end

    assign dv_valid[0] = pv_reg;
    assign dv_n1[0]    = m1_reg;
    assign dv_r1[0]    = '0;
    assign dv_n2[0]    = m2_reg;
    assign dv_r2[0]    = '0;
    assign dv_den[0]   = den_reg;
    assign dv_side[0]  = pside_reg;

    for (genvar j = 0; j < M_W; j++) begin : g_div
        qrs_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_valid[j]),
            .in_n1     (dv_n1[j]),
            .in_r1     (dv_r1[j]),
            .in_n2     (dv_n2[j]),
            .in_r2     (dv_r2[j]),
            .in_den    (dv_den[j]),
            .in_side   (dv_side[j]),
            .out_valid (dv_valid[j+1]),
            .out_n1    (dv_n1[j+1]),
            .out_r1    (dv_r1[j+1]),
            .out_n2    (dv_n2[j+1]),
            .out_r2    (dv_r2[j+1]),
            .out_den   (dv_den[j+1]),
            .out_side  (dv_side[j+1])
        );
    end

    // clamp to the 32-bit root field; top bit of the result is the clamp flag
    function automatic logic [ROOT_OUT_W:0] clamp(input logic signed [V_W-1:0] v);
        logic hi_same;
        hi_same = (v[V_W-1:ROOT_OUT_W-1] == '0) || (v[V_W-1:ROOT_OUT_W-1] == '1);
        if (hi_same) begin
            return {1'b0, v[ROOT_OUT_W-1:0]};
        end
        return {1'b1, v[V_W-1], {(ROOT_OUT_W-1){!v[V_W-1]}}};
    endfunction

    always_comb begin
        logic signed [V_W-1:0]   v1, v2, v2n;
        logic [ROOT_OUT_W:0]     c1, c2, c2n;
        dside_t                  sd;
        sd  = dv_side[M_W];
        v1  = sd.neg1 ? -V_W'(dv_n1[M_W]) : V_W'(dv_n1[M_W]);
        v2  = sd.neg2 ? -V_W'(dv_n2[M_W]) : V_W'(dv_n2[M_W]);
        v2n = -v2;
        c1  = clamp(v1);
        c2  = clamp(v2);
        c2n = clamp(v2n);
        case (sd.kind)
            KIND_DISTINCT: begin
                odata_next = {32'd0, c2[31:0], 32'd0, c1[31:0]};
                ouser_next = {c1[32] | c2[32], KIND_DISTINCT};
            end
            KIND_EQUAL: begin
                odata_next = {32'd0, c1[31:0], 32'd0, c1[31:0]};
                ouser_next = {c1[32], KIND_EQUAL};
            end
            KIND_COMPLEX: begin
                odata_next = {c2n[31:0], c1[31:0], c2[31:0], c1[31:0]};
                ouser_next = {c1[32] | c2[32] | c2n[32], KIND_COMPLEX};
            end
            default: begin
                odata_next = '0;
                ouser_next = {1'b0, KIND_DEGEN};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= dv_valid[M_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            odata_reg <= odata_next;
            ouser_reg <= ouser_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == KIND_DEGEN) |-> (m_tdata == '0) && !m_tuser[2])
        else $error("degenerate beat carries nonzero roots");

    a_real_no_imag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser[1:0] == KIND_DISTINCT) || (m_tuser[1:0] == KIND_EQUAL))
        |-> (m_tdata[63:32] == '0) && (m_tdata[127:96] == '0))
        else $error("real roots carry an imaginary part");

    a_same_real: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser[1:0] == KIND_EQUAL) || (m_tuser[1:0] == KIND_COMPLEX))
        |-> (m_tdata[31:0] == m_tdata[95:64]))
        else $error("paired roots differ in real part");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> (pv_reg == $past(pv_reg)) && (f_valid == $past(f_valid)))
        else $error("cell row moved during a stall");

endmodule

>>> tb/testbench.sv
// stream testbench for the quadratic root solver with a built-in root predictor
`timescale 1ns / 1ps

module testbench;
    import qrs_pkg::*;

    localparam int LATENCY   = 74;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        kind_t       kind;
        logic        sat;
        logic [31:0] r1re;
        logic [31:0] r1im;
        logic [31:0] r2re;
        logic [31:0] r2im;
    } roots_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;

    quadratic_root_solver dut (.*);

    logic [47:0] coeff_queue[$];
    roots_t      expected_roots[$];
    int          errors = 0;
    int          beats_in = 0, beats_out = 0;
    int          cycles = 0;
    int          sat_seen = 0;
    int          kind_seen[4] = '{0, 0, 0, 0};
    bit          calm = 0;
    bit          hold_req = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // floor(sqrt(d * 2^32)), bit by bit; exact flag tells if it is the true root
    function automatic logic [63:0] scaled_root(input logic [63:0] d, output bit exact);
        logic [127:0] target, t2;
        logic [63:0]  s, t;
        target = {64'd0, d} << (2 * FRAC);
        s = 0;
        for (int i = 62; i >= 0; i--) begin
            t = s | (64'd1 << i);
            t2 = t * t;
            if (t2 <= target) s = t;
        end
        t2 = s * s;
        exact = (t2 == target);
        return s;
    endfunction

    // floor(p + q*sqrt) with q in {-1,0,1}
    function automatic longint floor_add(longint p, int q, longint s, bit exact);
        if (q > 0) return p + s;
        if (q < 0) return p - s - (exact ? 0 : 1);
        return p;
    endfunction

    function automatic longint div_toward_zero(longint p, int q, longint s, bit exact,
                                               longint den);
        longint f;
        if (den < 0) begin
            p = -p; q = -q; den = -den;
        end
        f = floor_add(p, q, s, exact);
        if (f >= 0) return f / den;
        f = floor_add(-p, -q, s, exact);
        return -(f / den);
    endfunction

    function automatic logic [31:0] clamp32(longint v, ref logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1; return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            flag = 1; return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic roots_t solve_roots(logic [47:0] coeffs);
        roots_t r;
        longint a, b, c, disc, den, pb, s, v1r, v1i, v2r, v2i;
        bit exact;
        logic flag;
        a = longint'($signed(coeffs[15:0]));
        b = longint'($signed(coeffs[31:16]));
        c = longint'($signed(coeffs[47:32]));
        v1r = 0; v1i = 0; v2r = 0; v2i = 0; flag = 0; exact = 1;
        r = '0;
        if (a == 0) begin
            r.kind = KIND_DEGEN;
            return r;
        end
        disc = b * b - 4 * a * c;
        den = 2 * a;
        pb = (-b) <<< FRAC;
        if (disc > 0) begin
            r.kind = KIND_DISTINCT;
            s = longint'(scaled_root(disc, exact));
            v1r = div_toward_zero(pb, 1, s, exact, den);
            v2r = div_toward_zero(pb, -1, s, exact, den);
        end else if (disc == 0) begin
            r.kind = KIND_EQUAL;
            v1r = div_toward_zero(pb, 0, 0, 1, den);
            v2r = v1r;
        end else begin
            r.kind = KIND_COMPLEX;
            s = longint'(scaled_root(-disc, exact));
            v1r = div_toward_zero(pb, 0, 0, 1, den);
            v2r = v1r;
            v1i = div_toward_zero(0, 1, s, exact, den);
            v2i = -v1i;
        end
        r.r1re = clamp32(v1r, flag);
        r.r1im = clamp32(v1i, flag);
        r.r2re = clamp32(v2r, flag);
        r.r2im = clamp32(v2i, flag);
        r.sat = flag;
        return r;
    endfunction

    function automatic logic [47:0] pack_coeffs(int a, int b, int c);
        return {c[15:0], b[15:0], a[15:0]};
    endfunction

    function automatic logic [15:0] rand_coeff();
        case ($urandom_range(0, 5))
            0: return 16'(int'($urandom_range(0, 16)) - 8);
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2: return 16'(int'($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        logic [15:0] a, b, c;
        int k;
        coeff_queue.push_back(pack_coeffs(256, -768, 512));        // roots 1 and 2
        coeff_queue.push_back(pack_coeffs(256, 512, 256));         // double root
        coeff_queue.push_back(pack_coeffs(256, 0, 256));           // +-i
        coeff_queue.push_back(pack_coeffs(-256, 0, -256));         // negative a, complex
        coeff_queue.push_back(pack_coeffs(0, 1234, -55));          // degenerate
        coeff_queue.push_back(pack_coeffs(0, 0, 0));
        coeff_queue.push_back(pack_coeffs(1, 32767, 0));           // roots 0 and -32767
        coeff_queue.push_back(pack_coeffs(1, -32768, 0));
        coeff_queue.push_back(pack_coeffs(-1, 32767, 32767));
        coeff_queue.push_back(pack_coeffs(32767, 32767, 32767));
        coeff_queue.push_back(pack_coeffs(-32768, -32768, -32768));
        coeff_queue.push_back(pack_coeffs(-32768, 32767, 32767));
        coeff_queue.push_back(pack_coeffs(32767, -32768, -32768));
        coeff_queue.push_back(pack_coeffs(1, 0, -32768));
        coeff_queue.push_back(pack_coeffs(-1, 0, -32768));
        coeff_queue.push_back(pack_coeffs(1, 0, 1));
        coeff_queue.push_back(pack_coeffs(-1, 2, -1));             // equal, negative a
        coeff_queue.push_back(pack_coeffs(256, 256, -512));
        coeff_queue.push_back(pack_coeffs(3, 7, 2));               // exact sqrt, distinct roots
        coeff_queue.push_back(pack_coeffs(-3, 7, 5));
        for (int i = 0; i < 1200; i++) begin
            a = rand_coeff();
            b = rand_coeff();
            c = rand_coeff();
            k = $urandom_range(0, 9);
            // build perfect squares now and then so the equal case gets hit
            if (k == 0) begin
                a = 16'(int'($urandom_range(0, 64)) - 32);
                b = 16'(2 * int'($signed(a)) * (int'($urandom_range(0, 20)) - 10));
                c = (b == 0 || a == 0) ? 16'd0 : 16'($signed(b) * $signed(b)
                                                    / (4 * $signed(a)));
            end
            coeff_queue.push_back({c, b, a});
        end
    end

    // reset and end of run
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        wait (coeff_queue.size() == 0 && !s_tvalid && expected_roots.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("covered %0d beats: distinct %0d, equal %0d, complex %0d, degenerate %0d",
                 beats_in, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("saturated results %0d, results checked %0d", sat_seen, beats_out);
        if (errors == 0 && expected_roots.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // driver
    int src_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                beats_in <= beats_in + 1;
                expected_roots.push_back(solve_roots(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 0;
                end else if (coeff_queue.size() > 0) begin
                    s_tvalid <= 1;
                    s_tdata <= coeff_queue.pop_front();
                    if (!calm && $urandom_range(0, 15) == 0) src_gap <= $urandom_range(1, 12);
                end else begin
                    s_tvalid <= 0;
                end
            end
            if (coeff_queue.size() < 200) calm <= 1;
        end
    end

    // long hold-off on the result side once, counted here
    int hold_cnt = 0;
    bit hold_done = 0;
    always @(posedge aclk) begin
        if (aresetn && !hold_done && beats_in > 300) begin
            if (hold_cnt < 300) begin
                hold_req <= 1;
                hold_cnt <= hold_cnt + 1;
            end else begin
                hold_req <= 0;
                hold_done <= 1;
            end
        end
    end

    // monitor
    int sink_gap = 0;
    always @(posedge aclk) begin
        roots_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind = kind_t'(m_tuser[1:0]);
                got.sat  = m_tuser[2];
                got.r1re = m_tdata[31:0];
                got.r1im = m_tdata[63:32];
                got.r2re = m_tdata[95:64];
                got.r2im = m_tdata[127:96];
                beats_out <= beats_out + 1;
                if (expected_roots.size() == 0) begin
                    $display("%0t: unexpected result beat, actual %p", $realtime, got);
                    errors <= errors + 1;
                end else begin
                    want = expected_roots.pop_front();
                    kind_seen[want.kind] <= kind_seen[want.kind] + 1;
                    if (want.sat) sat_seen <= sat_seen + 1;
                    if (got.kind !== want.kind || got.sat !== want.sat
                        || got.r1re !== want.r1re || got.r1im !== want.r1im
                        || got.r2re !== want.r2re || got.r2im !== want.r2im) begin
                        $display("%0t: root mismatch expected %p actual %p",
                                 $realtime, want, got);
                        errors <= errors + 1;
                    end
                end
            end
            if (hold_req) begin
                m_tready <= 0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if (!calm && $urandom_range(0, 15) == 0) sink_gap <= $urandom_range(1, 12);
            end
        end
    end

endmodule
